// ===== rtl/pps_pkg.sv =====
package pps_pkg;

    localparam int unsigned TargetW = 32;
    localparam int unsigned ShiftW  = 3;
    localparam int unsigned TopW    = 15;
    localparam int unsigned HzW     = 24;
    localparam int unsigned DivW    = 32;
    localparam int unsigned CntW    = 5;

    localparam logic [HzW-1:0]     BaseClkHz = 24'd16000000;
    localparam logic [DivW-1:0]    TopMax    = 32'd32767;
    localparam logic [DivW-1:0]    TopMin    = 32'd3;
    localparam logic [ShiftW-1:0]  ShiftLast = 3'd7;
    localparam logic [TargetW-1:0] ErrNone   = 32'hFFFF_FFFF;
    localparam logic [CntW-1:0]    CntLast   = 5'd31;

endpackage

// ===== rtl/pps_in_if.sv =====
interface pps_in_if;
    logic                             valid;
    logic                             ready;
    logic [pps_pkg::TargetW-1:0]      target_hz;

    modport source (output valid, output target_hz, input ready);
    modport sink   (input valid, input target_hz, output ready);
endinterface

// ===== rtl/pps_out_if.sv =====
interface pps_out_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [pps_pkg::ShiftW-1:0]       prescale_shift;
    logic [pps_pkg::TopW-1:0]         counter_top;
    logic [pps_pkg::HzW-1:0]          actual_hz;

    modport source (output valid, output found, output prescale_shift, output counter_top,
                    output actual_hz, input ready);
    modport sink   (input valid, input found, input prescale_shift, input counter_top,
                    input actual_hz, output ready);
endinterface

// ===== rtl/pwm_prescaler_top_search.sv =====
// PWM prescaler search: for a wanted frequency the block walks the eight power-of-two
// prescaler shifts of the 16 MHz base clock, finds the rounded counter top for each
// (clamped to at least 3, shifts with a top above 32767 skipped), the resulting
// frequency and its error, and returns the first shift with the least error. All
// division runs on one restoring divider that yields one quotient bit per cycle;
// each shift runs one division for its top and, unless it is skipped, a second one for
// its frequency. An exact match ends the search early, and a zero target ends it at
// once with no division. The block takes one word at a time; a finished result waits
// in an output register while the next word is accepted.
module pwm_prescaler_top_search (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_in_if.sink    i_in,
    pps_out_if.source o_out
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_LOAD    = 6'b000010,
        S_DIV     = 6'b000100,
        S_TOP_CHK = 6'b001000,
        S_HZ_CHK  = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_phase_hz, n_phase_hz;
    logic [pps_pkg::CntW-1:0]        r_cnt, n_cnt;
    logic [pps_pkg::DivW-1:0]        r_rem, n_rem;
    logic [pps_pkg::DivW-1:0]        r_quo, n_quo;
    logic [pps_pkg::DivW-1:0]        r_den, n_den;
    logic [pps_pkg::TargetW-1:0]     r_target, n_target;
    logic [pps_pkg::ShiftW-1:0]      r_shift, n_shift;
    logic [pps_pkg::TopW-1:0]        r_top, n_top;
    logic                            r_have, n_have;
    logic [pps_pkg::TargetW-1:0]     r_best_err, n_best_err;
    logic [pps_pkg::ShiftW-1:0]      r_best_shift, n_best_shift;
    logic [pps_pkg::TopW-1:0]        r_best_top, n_best_top;
    logic [pps_pkg::HzW-1:0]         r_best_hz, n_best_hz;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_found;
    logic [pps_pkg::ShiftW-1:0]      r_out_shift;
    logic [pps_pkg::TopW-1:0]        r_out_top;
    logic [pps_pkg::HzW-1:0]         r_out_hz;

    logic [pps_pkg::HzW-1:0]         clk_div;
    logic [pps_pkg::DivW:0]          rem_sh;
    logic [pps_pkg::DivW:0]          den_ext;
    logic                            div_ge;
    logic [pps_pkg::DivW:0]          div_diff;
    logic [pps_pkg::DivW-1:0]        top_full;
    logic [pps_pkg::DivW-1:0]        hz_full;
    logic [pps_pkg::TargetW-1:0]     err;
    logic                            out_load;
    logic                            in_take;

    assign clk_div  = pps_pkg::BaseClkHz >> r_shift;

    // restoring divider step
    assign rem_sh   = {r_rem, r_quo[pps_pkg::DivW-1]};
    assign den_ext  = {1'b0, r_den};
    assign div_ge   = rem_sh >= den_ext;
    assign div_diff = rem_sh - den_ext;

    assign top_full = (r_quo < pps_pkg::TopMin) ? pps_pkg::TopMin : r_quo;
    assign hz_full  = r_quo;
    assign err      = (hz_full >= r_target) ? (hz_full - r_target) : (r_target - hz_full);

    assign in_take  = i_in.valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state      = r_state;
        n_phase_hz   = r_phase_hz;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_den        = r_den;
        n_target     = r_target;
        n_shift      = r_shift;
        n_top        = r_top;
        n_have       = r_have;
        n_best_err   = r_best_err;
        n_best_shift = r_best_shift;
        n_best_top   = r_best_top;
        n_best_hz    = r_best_hz;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_target     = i_in.target_hz;
                    n_shift      = '0;
                    n_have       = 1'b0;
                    n_best_err   = pps_pkg::ErrNone;
                    n_best_shift = '0;
                    n_best_top   = '0;
                    n_best_hz    = '0;
                    n_state      = (i_in.target_hz == '0) ? S_DONE : S_LOAD;
                end
            end
            S_LOAD: begin
                // rounded top: (clk + target/2) / target, sum fits in 32 bits
                n_quo      = {8'd0, clk_div} + (r_target >> 1);
                n_den      = r_target;
                n_rem      = '0;
                n_cnt      = '0;
                n_phase_hz = 1'b0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[pps_pkg::DivW-2:0], div_ge};
                n_rem = div_ge ? div_diff[pps_pkg::DivW-1:0] : rem_sh[pps_pkg::DivW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == pps_pkg::CntLast) begin
                    n_state = r_phase_hz ? S_HZ_CHK : S_TOP_CHK;
                end
            end
            S_TOP_CHK: begin
                if (top_full > pps_pkg::TopMax) begin
                    if (r_shift == pps_pkg::ShiftLast) begin
                        n_state = S_DONE;
                    end else begin
                        n_shift = r_shift + 1'b1;
                        n_state = S_LOAD;
                    end
                end else begin
                    n_top      = top_full[pps_pkg::TopW-1:0];
                    n_quo      = {8'd0, clk_div};
                    n_den      = top_full;
                    n_rem      = '0;
                    n_cnt      = '0;
                    n_phase_hz = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_HZ_CHK: begin
                if (!r_have || err < r_best_err) begin
                    n_have       = 1'b1;
                    n_best_err   = err;
                    n_best_shift = r_shift;
                    n_best_top   = r_top;
                    n_best_hz    = hz_full[pps_pkg::HzW-1:0];
                end
                if ((!r_have || err < r_best_err) && err == '0) begin
                    n_state = S_DONE;
                end else if (r_shift == pps_pkg::ShiftLast) begin
                    n_state = S_DONE;
                end else begin
                    n_shift = r_shift + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase_hz   <= n_phase_hz;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_den        <= n_den;
        r_target     <= n_target;
        r_shift      <= n_shift;
        r_top        <= n_top;
        r_have       <= n_have;
        r_best_err   <= n_best_err;
        r_best_shift <= n_best_shift;
        r_best_top   <= n_best_top;
        r_best_hz    <= n_best_hz;
        if (out_load) begin
            r_out_found <= r_have;
            r_out_shift <= r_best_shift;
            r_out_top   <= r_best_top;
            r_out_hz    <= r_best_hz;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_out_found;
    assign o_out.prescale_shift = r_out_shift;
    assign o_out.counter_top    = r_out_top;
    assign o_out.actual_hz      = r_out_hz;

    a_found_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (o_out.counter_top >= 15'd3))
        else $error("found result with counter top below minimum");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |->
            (o_out.prescale_shift == '0 && o_out.counter_top == '0 && o_out.actual_hz == '0))
        else $error("not found result with non-zero fields");

    // the step count wraps back to zero as the divider finishes
    a_cnt_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_DIV))
        else $error("divider count out of step");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while busy");

endmodule

// ===== test/pwm_prescaler_top_search_tb.sv =====
`timescale 1ns / 1ps

module pwm_prescaler_top_search_tb;

    typedef struct packed {
        logic                       found;
        logic [pps_pkg::ShiftW-1:0] shift;
        logic [pps_pkg::TopW-1:0]   top;
        logic [pps_pkg::HzW-1:0]    hz;
    } t_prescale_res;

    logic i_clk;
    logic i_rst_n;

    pps_in_if  in_ch ();
    pps_out_if out_ch ();

    pwm_prescaler_top_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    logic [pps_pkg::TargetW-1:0] pending_hz_q[$];
    t_prescale_res               expected_setting_q[$];
    t_prescale_res               got_res;
    t_prescale_res               want_res;
    int                          mismatch_count = 0;
    int                          tx_idle_pct    = 0;
    int                          rx_idle_pct    = 0;
    int                          phase_no       = 0;
    logic                        hold_rx        = 1'b0;

    logic [pps_pkg::TargetW-1:0] directed_hz [0:22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd244, 32'd488, 32'd489,
        32'd1000, 32'd1234, 32'd20000, 32'd125000, 32'd1000000, 32'd5333333,
        32'd8000000, 32'd15999999, 32'd16000000, 32'd16000001,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hFFFF_FFFF
    };

    // walk the shifts in ascending order, first least-error candidate wins
    function automatic t_prescale_res search_prescale(
        input logic [pps_pkg::TargetW-1:0] target);
        t_prescale_res               best;
        logic [pps_pkg::TargetW-1:0] best_err;
        logic [pps_pkg::DivW-1:0]    clk_div;
        logic [pps_pkg::DivW-1:0]    top_w;
        logic [pps_pkg::DivW-1:0]    hz_w;
        logic [pps_pkg::DivW-1:0]    err;
        logic [63:0]                 num;
        logic [63:0]                 den;
        logic [63:0]                 top64;
        logic                        done;
        int                          s;
        best     = '0;
        best_err = pps_pkg::ErrNone;
        done     = 1'b0;
        if (target != '0) begin
            for (s = 0; s <= int'(pps_pkg::ShiftLast); s++) begin
                if (!done) begin
                    clk_div = {8'd0, pps_pkg::BaseClkHz} >> s;
                    num     = clk_div;
                    num     = num + (target >> 1);
                    den     = target;
                    top64   = num / den;
                    if (top64 < pps_pkg::TopMin) top64 = pps_pkg::TopMin;
                    // a shift whose top does not fit is skipped
                    if (top64 <= pps_pkg::TopMax) begin
                        top_w = top64[pps_pkg::DivW-1:0];
                        hz_w  = clk_div / top_w;
                        err   = (hz_w >= target) ? (hz_w - target) : (target - hz_w);
                        if (!best.found || err < best_err) begin
                            best.found = 1'b1;
                            best_err   = err;
                            best.shift = s[pps_pkg::ShiftW-1:0];
                            best.top   = top_w[pps_pkg::TopW-1:0];
                            best.hz    = hz_w[pps_pkg::HzW-1:0];
                            if (err == '0) done = 1'b1;
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    function automatic logic [pps_pkg::TargetW-1:0] pick_target();
        logic [pps_pkg::DivW-1:0]    clk_div;
        logic [pps_pkg::DivW-1:0]    top_w;
        logic [pps_pkg::TargetW-1:0] t;
        clk_div = '0;
        top_w   = '0;
        case ($urandom_range(9))
            0:       t = $urandom;
            1:       t = $urandom_range(600, 0);
            2, 3:    t = $urandom_range(200000, 1);
            4: begin
                // quotients of a divided clock by a legal top aim at an exact match and the early stop
                clk_div = {8'd0, pps_pkg::BaseClkHz} >> $urandom_range(7);
                top_w   = $urandom_range(32767, 3);
                t       = clk_div / top_w;
            end
            5:       t = $urandom_range(16000000, 1000000);
            6: begin
                clk_div = {8'd0, pps_pkg::BaseClkHz} >> $urandom_range(7);
                t       = clk_div + $urandom_range(8) - 4;
            end
            default: t = $urandom_range(50000, 1);
        endcase
        return t;
    endfunction

    task automatic report_bad(input string what, input t_prescale_res want,
                              input t_prescale_res got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected found=%0d shift=%0d top=%0d hz=%0d, %s%0d %s%0d %s%0d %s%0d",
                     what, want.found, want.shift, want.top, want.hz,
                     "got found=", got.found, "shift=", got.shift,
                     "top=", got.top, "hz=", got.hz);
    endtask

    task automatic wait_drained();
        while (pending_hz_q.size() != 0 || in_ch.valid || expected_setting_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // driver: offer the next pending word once the previous one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_setting_q.push_back(search_prescale(in_ch.target_hz));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_hz_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.target_hz <= pending_hz_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_res = {out_ch.found, out_ch.prescale_shift, out_ch.counter_top,
                           out_ch.actual_hz};
                if (expected_setting_q.size() == 0) begin
                    report_bad("unexpected word", '0, got_res);
                end else begin
                    want_res = expected_setting_q.pop_front();
                    if (got_res.found !== want_res.found || got_res.shift !== want_res.shift ||
                        got_res.top !== want_res.top || got_res.hz !== want_res.hz)
                        report_bad("mismatch", want_res, got_res);
                end
            end
            out_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off in the first random phase so the input backs up
    initial begin
        wait (phase_no == 1);
        hold_rx <= 1'b1;
        repeat (5000) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.target_hz = '0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_hz[k]) pending_hz_q.push_back(directed_hz[k]);
        wait_drained();

        for (int p = 1; p <= 4; p++) begin
            case (p)
                1: begin tx_idle_pct <= 0;  rx_idle_pct <= 0;  end
                2: begin tx_idle_pct <= 51; rx_idle_pct <= 0;  end
                3: begin tx_idle_pct <= 0;  rx_idle_pct <= 51; end
                default: begin tx_idle_pct <= 23; rx_idle_pct <= 23; end
            endcase
            phase_no <= p;
            for (int n = 0; n < 250; n++) pending_hz_q.push_back(pick_target());
            // sender pauses until every word of the phase has come back
            wait_drained();
        end

        repeat (600) @(posedge i_clk);
        if (expected_setting_q.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
